// File: rtl/mec_pkg.sv
// shared types, constants and threshold tables of the motion event classifier
`timescale 1ns / 1ps
package mec_pkg;

  localparam int ONE_G       = 4096;
  localparam int LEVELS      = 5;
  localparam int LEVEL_W     = 3;
  localparam int ROW_W       = $clog2(LEVELS);
  localparam int LEVEL_RESET = 2;
  localparam int AXIS_W      = 16;
  localparam int SUM_W       = 32;
  localparam int MAG_W       = 16;
  localparam int REM_W       = MAG_W + 3;
  localparam int STEP_W      = $clog2(SUM_W / 2);
  localparam int CNT_W       = 16;
  localparam int TIME_W      = 48;
  localparam int FLAG_W      = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // sensor flag bits
  localparam int FLAG_IMPACT = 0;
  localparam int FLAG_MOTION = 1;
  localparam int FLAG_WAKE   = 2;

  typedef enum logic [1:0] {
    CLASS_NONE   = 2'd0,
    CLASS_SOFT   = 2'd1,
    CLASS_HARD   = 2'd2,
    CLASS_IMPACT = 2'd3
  } class_e;

  // accel thresholds in counts: floor(milli-g * ONE_G / 1000)
  localparam logic [MAG_W-1:0] ACC_SOFT [LEVELS] = '{
    MAG_W'(250 * ONE_G / 1000), MAG_W'(150 * ONE_G / 1000), MAG_W'(80 * ONE_G / 1000),
    MAG_W'(20 * ONE_G / 1000), MAG_W'(10 * ONE_G / 1000)
  };
  localparam logic [MAG_W-1:0] ACC_HARD [LEVELS] = '{
    MAG_W'(700 * ONE_G / 1000), MAG_W'(500 * ONE_G / 1000), MAG_W'(300 * ONE_G / 1000),
    MAG_W'(150 * ONE_G / 1000), MAG_W'(80 * ONE_G / 1000)
  };
  // gyro thresholds in 1/16 deg/s
  localparam logic [MAG_W-1:0] GYRO_SOFT [LEVELS] = '{
    MAG_W'(240), MAG_W'(160), MAG_W'(48), MAG_W'(16), MAG_W'(8)
  };
  localparam logic [MAG_W-1:0] GYRO_HARD [LEVELS] = '{
    MAG_W'(960), MAG_W'(640), MAG_W'(320), MAG_W'(160), MAG_W'(80)
  };

  // classified sample travelling from front to back
  typedef struct packed {
    class_e             cls;
    logic               fwd;
    logic [MAG_W-1:0]   dev;
    logic [MAG_W-1:0]   gmag;
    logic [TIME_W-1:0]  now;
    logic               clr;
  } entry_t;

endpackage

// File: rtl/mec_if.sv
// sample and result channel interfaces
`timescale 1ns / 1ps
interface mec_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mec_pkg::AXIS_W-1:0]     accel_x;
  logic signed [mec_pkg::AXIS_W-1:0]     accel_y;
  logic signed [mec_pkg::AXIS_W-1:0]     accel_z;
  logic signed [mec_pkg::AXIS_W-1:0]     gyro_x;
  logic signed [mec_pkg::AXIS_W-1:0]     gyro_y;
  logic signed [mec_pkg::AXIS_W-1:0]     gyro_z;
  logic        [mec_pkg::FLAG_W-1:0]     sensor_flags;
  logic                                  armed;
  logic                                  active_state;
  logic        [mec_pkg::TIME_W-1:0]     now_us;
  logic                                  clear_metrics;

  modport source (
    output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
    output sensor_flags, armed, active_state, now_us, clear_metrics,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
    input  sensor_flags, armed, active_state, now_us, clear_metrics,
    output ready
  );
endinterface

interface mec_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       event_class;
  logic                             forward_event;
  logic [mec_pkg::MAG_W-1:0]        peak_accel_dev;
  logic [mec_pkg::MAG_W-1:0]        peak_gyro_mag;
  logic [mec_pkg::CNT_W-1:0]        hard_count;
  logic [mec_pkg::CNT_W-1:0]        soft_count;
  logic [mec_pkg::TIME_W-1:0]       last_move_time;
  logic [mec_pkg::TIME_W-1:0]       last_hard_time;

  modport source (
    output valid, event_class, forward_event, peak_accel_dev, peak_gyro_mag,
    output hard_count, soft_count, last_move_time, last_hard_time,
    input  ready
  );
  modport sink (
    input  valid, event_class, forward_event, peak_accel_dev, peak_gyro_mag,
    input  hard_count, soft_count, last_move_time, last_hard_time,
    output ready
  );
endinterface

// File: rtl/motion_event_classifier.sv
// motion event classifier: a sample passes the front, the queue and the back's output register
// the front accepts no new sample until it has pushed the last one: the shared squarer and the
// two-bit-per-step root unit in the front handle the accel vector, then the gyro vector
// the queue and output register let the front start the next sample while a result waits
// reset clears peaks, counters and timestamps to zero and sets the sensitivity level to 2
`timescale 1ns / 1ps
module motion_event_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mec_pkg::LEVEL_W-1:0] cfg_wdata_i,
  mec_in_if.sink                      in_i,
  mec_out_if.source                   out_o
);

  logic [mec_pkg::LEVEL_W-1:0] level_q;

  logic            push_valid, push_ready;
  mec_pkg::entry_t push_data;
  logic            pop_valid, pop_ready;
  mec_pkg::entry_t pop_data;

  // out-of-range levels fall back to the default row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= mec_pkg::LEVEL_W'(mec_pkg::LEVEL_RESET);
    end else if (cfg_we_i) begin
      level_q <= (cfg_wdata_i > mec_pkg::LEVEL_W'(mec_pkg::LEVELS - 1))
               ? mec_pkg::LEVEL_W'(mec_pkg::LEVEL_RESET) : cfg_wdata_i;
    end
  end

  mec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .level_i      (level_q),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  mec_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  mec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

// File: rtl/mec_front.sv
// front end: takes a sample, forms both magnitudes iteratively and classifies it
`timescale 1ns / 1ps
module mec_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [mec_pkg::LEVEL_W-1:0]     level_i,
  mec_in_if.sink                          in_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output mec_pkg::entry_t                 push_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SQUARE,
    S_ROOT,
    S_PUSH
  } state_e;

  state_e                            state_q, state_d;
  logic [mec_pkg::STEP_W-1:0]        cnt_q, cnt_d;
  logic                              phase_q, phase_d;   // 0 accel, 1 gyro

  logic signed [mec_pkg::AXIS_W-1:0] acc_q [3];
  logic signed [mec_pkg::AXIS_W-1:0] gyr_q [3];
  logic [mec_pkg::FLAG_W-1:0]        flags_q;
  logic                              armed_q;
  logic                              active_q;
  logic [mec_pkg::TIME_W-1:0]        now_q;
  logic                              clr_q;
  logic [mec_pkg::SUM_W-1:0]         sum_q;
  logic [mec_pkg::REM_W-1:0]         rem_q;
  logic [mec_pkg::MAG_W-1:0]         root_q;
  logic [mec_pkg::MAG_W-1:0]         amag_q;
  logic [mec_pkg::MAG_W-1:0]         gmag_q;

  logic                              accept;
  logic signed [mec_pkg::AXIS_W-1:0] operand;
  logic [mec_pkg::AXIS_W-1:0]        abs_v;
  logic [mec_pkg::SUM_W-1:0]         square;
  logic [mec_pkg::REM_W-1:0]         rem_shift;
  logic [mec_pkg::REM_W-1:0]         trial;
  logic                              take;
  logic [mec_pkg::MAG_W-1:0]         root_next;

  logic [mec_pkg::LEVEL_W-1:0]       row;
  logic [mec_pkg::ROW_W-1:0]         row_idx;
  logic [mec_pkg::MAG_W-1:0]         dev;
  logic                              over_hard;
  logic                              over_soft;
  mec_pkg::class_e                   cls;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // one shared squarer, one axis a cycle
  assign operand = phase_q ? gyr_q[cnt_q[1:0]] : acc_q[cnt_q[1:0]];
  assign abs_v   = operand[mec_pkg::AXIS_W-1] ? mec_pkg::AXIS_W'(-operand)
                                              : mec_pkg::AXIS_W'(operand);
  assign square  = {{(mec_pkg::SUM_W - mec_pkg::AXIS_W){1'b0}}, abs_v}
                 * {{(mec_pkg::SUM_W - mec_pkg::AXIS_W){1'b0}}, abs_v};

  // digit-by-digit square root, two radicand bits a step
  assign rem_shift = {rem_q[mec_pkg::REM_W-3:0], sum_q[mec_pkg::SUM_W-1 -: 2]};
  assign trial     = mec_pkg::REM_W'({root_q, 2'b01});
  assign take      = (rem_shift >= trial);
  assign root_next = {root_q[mec_pkg::MAG_W-2:0], take};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SQUARE;
          cnt_d   = '0;
          phase_d = 1'b0;
        end
      end
      S_SQUARE: begin
        if (cnt_q == mec_pkg::STEP_W'(2)) begin
          state_d = S_ROOT;
          cnt_d   = '1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ROOT: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (phase_q) begin
            state_d = S_PUSH;
          end else begin
            state_d = S_SQUARE;
            phase_d = 1'b1;
            cnt_d   = '0;
          end
        end
      end
      S_PUSH: begin
        if (push_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q[0] <= in_i.accel_x;
      acc_q[1] <= in_i.accel_y;
      acc_q[2] <= in_i.accel_z;
      gyr_q[0] <= in_i.gyro_x;
      gyr_q[1] <= in_i.gyro_y;
      gyr_q[2] <= in_i.gyro_z;
      flags_q  <= in_i.sensor_flags;
      armed_q  <= in_i.armed;
      active_q <= in_i.active_state;
      now_q    <= in_i.now_us;
      clr_q    <= in_i.clear_metrics;
      sum_q    <= '0;
    end
    if (state_q == S_SQUARE) begin
      sum_q  <= sum_q + square;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (state_q == S_ROOT) begin
      rem_q  <= take ? (rem_shift - trial) : rem_shift;
      root_q <= root_next;
      // last step of the accel root clears the sum for the gyro pass
      if (cnt_q == '0 && !phase_q) begin
        sum_q  <= '0;
        amag_q <= root_next;
      end else begin
        sum_q <= {sum_q[mec_pkg::SUM_W-3:0], 2'b00};
      end
      if (cnt_q == '0 && phase_q) begin
        gmag_q <= root_next;
      end
    end
  end

  // classification against the sensor flags and the selected threshold row
  always_comb begin
    row = (level_i > mec_pkg::LEVEL_W'(mec_pkg::LEVELS - 1))
        ? mec_pkg::LEVEL_W'(mec_pkg::LEVELS - 1) : level_i;
    row_idx = row[mec_pkg::ROW_W-1:0];
    dev = (amag_q >= mec_pkg::MAG_W'(mec_pkg::ONE_G))
        ? amag_q - mec_pkg::MAG_W'(mec_pkg::ONE_G)
        : mec_pkg::MAG_W'(mec_pkg::ONE_G) - amag_q;
    over_hard = (dev > mec_pkg::ACC_HARD[row_idx]) || (gmag_q > mec_pkg::GYRO_HARD[row_idx]);
    over_soft = flags_q[mec_pkg::FLAG_MOTION] || flags_q[mec_pkg::FLAG_WAKE]
             || (dev > mec_pkg::ACC_SOFT[row_idx]) || (gmag_q > mec_pkg::GYRO_SOFT[row_idx]);
    if (flags_q[mec_pkg::FLAG_IMPACT]) begin
      cls = mec_pkg::CLASS_IMPACT;
    end else if (over_hard) begin
      cls = mec_pkg::CLASS_HARD;
    end else if (over_soft) begin
      cls = mec_pkg::CLASS_SOFT;
    end else begin
      cls = mec_pkg::CLASS_NONE;
    end
  end

  assign push_valid_o     = (state_q == S_PUSH);
  assign push_data_o.cls  = cls;
  assign push_data_o.fwd  = (cls != mec_pkg::CLASS_NONE) && (armed_q || active_q);
  assign push_data_o.dev  = dev;
  assign push_data_o.gmag = gmag_q;
  assign push_data_o.now  = now_q;
  assign push_data_o.clr  = clr_q;

endmodule

// File: rtl/mec_queue.sv
// short queue of classified samples between front and back
`timescale 1ns / 1ps
module mec_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  mec_pkg::entry_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output mec_pkg::entry_t pop_data_o
);

  localparam logic [mec_pkg::PTR_W-1:0] LAST = mec_pkg::PTR_W'(mec_pkg::QUEUE_DEPTH - 1);

  mec_pkg::entry_t               mem_q [mec_pkg::QUEUE_DEPTH];
  logic [mec_pkg::PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [mec_pkg::PTR_W:0]       count_q;
  logic                          push, pop;

  assign push_ready_o = (count_q != (mec_pkg::PTR_W + 1)'(mec_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/mec_back.sv
// back end: applies a classified sample to peaks, counters and timestamps
`timescale 1ns / 1ps
module mec_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  mec_pkg::entry_t pop_data_i,
  mec_out_if.source       out_o
);

  logic                          out_valid_q;
  mec_pkg::class_e               cls_q;
  logic                          fwd_q;
  logic [mec_pkg::MAG_W-1:0]     peak_dev_q, peak_dev_d;
  logic [mec_pkg::MAG_W-1:0]     peak_rate_q, peak_rate_d;
  logic [mec_pkg::CNT_W-1:0]     hard_cnt_q, hard_cnt_d;
  logic [mec_pkg::CNT_W-1:0]     soft_cnt_q, soft_cnt_d;
  logic [mec_pkg::TIME_W-1:0]    move_time_q, move_time_d;
  logic [mec_pkg::TIME_W-1:0]    hard_time_q, hard_time_d;

  logic                          load;
  logic                          is_event;
  logic                          is_hard;
  logic [mec_pkg::MAG_W-1:0]     dev_base, rate_base;
  logic [mec_pkg::CNT_W-1:0]     hard_base, soft_base;

  // the output register frees up on the transfer that empties it
  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign load        = pop_valid_i && pop_ready_o;

  always_comb begin
    is_event  = (pop_data_i.cls != mec_pkg::CLASS_NONE);
    is_hard   = (pop_data_i.cls == mec_pkg::CLASS_HARD)
             || (pop_data_i.cls == mec_pkg::CLASS_IMPACT);
    dev_base  = pop_data_i.clr ? '0 : peak_dev_q;
    rate_base = pop_data_i.clr ? '0 : peak_rate_q;
    hard_base = pop_data_i.clr ? '0 : hard_cnt_q;
    soft_base = pop_data_i.clr ? '0 : soft_cnt_q;

    peak_dev_d  = dev_base;
    peak_rate_d = rate_base;
    hard_cnt_d  = hard_base;
    soft_cnt_d  = soft_base;
    move_time_d = move_time_q;
    hard_time_d = hard_time_q;
    if (is_event) begin
      move_time_d = pop_data_i.now;
      if (is_hard) begin
        hard_time_d = pop_data_i.now;
        if (hard_base != '1) begin
          hard_cnt_d = hard_base + 1'b1;
        end
      end else if (soft_base != '1) begin
        soft_cnt_d = soft_base + 1'b1;
      end
      if (pop_data_i.dev > dev_base) begin
        peak_dev_d = pop_data_i.dev;
      end
      if (pop_data_i.gmag > rate_base) begin
        peak_rate_d = pop_data_i.gmag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      peak_dev_q  <= '0;
      peak_rate_q <= '0;
      hard_cnt_q  <= '0;
      soft_cnt_q  <= '0;
      move_time_q <= '0;
      hard_time_q <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        peak_dev_q  <= peak_dev_d;
        peak_rate_q <= peak_rate_d;
        hard_cnt_q  <= hard_cnt_d;
        soft_cnt_q  <= soft_cnt_d;
        move_time_q <= move_time_d;
        hard_time_q <= hard_time_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cls_q <= pop_data_i.cls;
      fwd_q <= pop_data_i.fwd;
    end
  end

  // state only changes on a load, so it doubles as the result payload
  assign out_o.valid          = out_valid_q;
  assign out_o.event_class    = cls_q;
  assign out_o.forward_event  = fwd_q;
  assign out_o.peak_accel_dev = peak_dev_q;
  assign out_o.peak_gyro_mag  = peak_rate_q;
  assign out_o.hard_count     = hard_cnt_q;
  assign out_o.soft_count     = soft_cnt_q;
  assign out_o.last_move_time = move_time_q;
  assign out_o.last_hard_time = hard_time_q;

endmodule

// File: dv/motion_event_classifier_test.sv
// testbench for the motion event classifier: samples driven, predicted results checked
`timescale 1ns / 1ps

typedef struct {
  logic signed [mec_pkg::AXIS_W-1:0] acc [3];
  logic signed [mec_pkg::AXIS_W-1:0] gyr [3];
  logic [mec_pkg::FLAG_W-1:0]        flags;
  logic                              armed;
  logic                              active;
  logic [mec_pkg::TIME_W-1:0]        now;
  logic                              clr;
} sample_t;

typedef struct {
  mec_pkg::class_e            cls;
  logic                       fwd;
  logic [mec_pkg::MAG_W-1:0]  peak_dev;
  logic [mec_pkg::MAG_W-1:0]  peak_gyro;
  logic [mec_pkg::CNT_W-1:0]  hard_cnt;
  logic [mec_pkg::CNT_W-1:0]  soft_cnt;
  logic [mec_pkg::TIME_W-1:0] move_time;
  logic [mec_pkg::TIME_W-1:0] hard_time;
} report_t;

localparam int unsigned ONE_G_COUNTS = 4096;
localparam int unsigned LAST_ROW     = 4;
// accel limits in milli-g, gyro limits in 1/16 deg/s
localparam int unsigned ACC_SOFT_MG [5] = '{250, 150, 80, 20, 10};
localparam int unsigned ACC_HARD_MG [5] = '{700, 500, 300, 150, 80};
localparam int unsigned GYRO_SOFT_CT [5] = '{240, 160, 48, 16, 8};
localparam int unsigned GYRO_HARD_CT [5] = '{960, 640, 320, 160, 80};

class motion_tally;
  logic [mec_pkg::LEVEL_W-1:0] level;
  logic [mec_pkg::MAG_W-1:0]   peak_dev;
  logic [mec_pkg::MAG_W-1:0]   peak_gyro;
  logic [mec_pkg::CNT_W-1:0]   hard_cnt;
  logic [mec_pkg::CNT_W-1:0]   soft_cnt;
  logic [mec_pkg::TIME_W-1:0]  move_time;
  logic [mec_pkg::TIME_W-1:0]  hard_time;
  report_t                     pending_reports [$];
  int                          errors;

  function new();
    level     = 3'd2;
    peak_dev  = '0;
    peak_gyro = '0;
    hard_cnt  = '0;
    soft_cnt  = '0;
    move_time = '0;
    hard_time = '0;
    errors    = 0;
  endfunction

  function void write_level(logic [mec_pkg::LEVEL_W-1:0] v);
    level = (v > 3'(LAST_ROW)) ? 3'd2 : v;
  endfunction

  // floor square root of the sum of squares, one result bit per pass
  function logic [mec_pkg::MAG_W-1:0] vector_length(logic signed [mec_pkg::AXIS_W-1:0] v [3]);
    logic [63:0] sum;
    logic [63:0] trial;
    logic [mec_pkg::MAG_W-1:0] root;
    int a;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      a = int'(v[i]);
      if (a < 0) a = -a;
      sum += 64'(a) * 64'(a);
    end
    root = '0;
    for (int b = mec_pkg::MAG_W - 1; b >= 0; b--) begin
      trial = 64'(root) | (64'd1 << b);
      if (trial * trial <= sum) root = trial[mec_pkg::MAG_W-1:0];
    end
    return root;
  endfunction

  function void note_sample(sample_t s);
    logic [mec_pkg::MAG_W-1:0] amag;
    logic [mec_pkg::MAG_W-1:0] gmag;
    logic [mec_pkg::MAG_W-1:0] dev;
    int unsigned row;
    int unsigned a_soft;
    int unsigned a_hard;
    mec_pkg::class_e cls;
    report_t r;
    amag = vector_length(s.acc);
    gmag = vector_length(s.gyr);
    dev  = (amag >= ONE_G_COUNTS) ? amag - 16'(ONE_G_COUNTS) : 16'(ONE_G_COUNTS) - amag;
    row  = (level > LAST_ROW) ? LAST_ROW : level;
    a_soft = ACC_SOFT_MG[row] * ONE_G_COUNTS / 1000;
    a_hard = ACC_HARD_MG[row] * ONE_G_COUNTS / 1000;

    if (s.flags[mec_pkg::FLAG_IMPACT])
      cls = mec_pkg::CLASS_IMPACT;
    else if (dev > a_hard || gmag > GYRO_HARD_CT[row])
      cls = mec_pkg::CLASS_HARD;
    else if (s.flags[mec_pkg::FLAG_MOTION] || s.flags[mec_pkg::FLAG_WAKE] ||
             dev > a_soft || gmag > GYRO_SOFT_CT[row])
      cls = mec_pkg::CLASS_SOFT;
    else
      cls = mec_pkg::CLASS_NONE;

    // clear comes first; timestamps are kept
    if (s.clr) begin
      peak_dev  = '0;
      peak_gyro = '0;
      hard_cnt  = '0;
      soft_cnt  = '0;
    end

    if (cls != mec_pkg::CLASS_NONE) begin
      move_time = s.now;
      if (cls == mec_pkg::CLASS_HARD || cls == mec_pkg::CLASS_IMPACT) begin
        hard_time = s.now;
        if (hard_cnt != '1) hard_cnt++;
      end else begin
        if (soft_cnt != '1) soft_cnt++;
      end
      if (dev > peak_dev) peak_dev = dev;
      if (gmag > peak_gyro) peak_gyro = gmag;
    end

    r.cls       = cls;
    r.fwd       = (cls != mec_pkg::CLASS_NONE) && (s.armed || s.active);
    r.peak_dev  = peak_dev;
    r.peak_gyro = peak_gyro;
    r.hard_cnt  = hard_cnt;
    r.soft_cnt  = soft_cnt;
    r.move_time = move_time;
    r.hard_time = hard_time;
    pending_reports.push_back(r);
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_report(report_t got);
    report_t want;
    if (pending_reports.size() == 0) begin
      errors++;
      $display("%0t: result with none pending: expected nothing, actual class %0d peak %0h",
               $time, got.cls, got.peak_dev);
      return;
    end
    want = pending_reports.pop_front();
    compare_field("event_class", 64'(want.cls), 64'(got.cls));
    compare_field("forward_event", 64'(want.fwd), 64'(got.fwd));
    compare_field("peak_accel_dev", 64'(want.peak_dev), 64'(got.peak_dev));
    compare_field("peak_gyro_mag", 64'(want.peak_gyro), 64'(got.peak_gyro));
    compare_field("hard_count", 64'(want.hard_cnt), 64'(got.hard_cnt));
    compare_field("soft_count", 64'(want.soft_cnt), 64'(got.soft_cnt));
    compare_field("last_move_time", 64'(want.move_time), 64'(got.move_time));
    compare_field("last_hard_time", 64'(want.hard_time), 64'(got.hard_time));
  endfunction

  function int unsigned outstanding();
    return pending_reports.size();
  endfunction
endclass

module motion_event_classifier_test;

  localparam logic [mec_pkg::FLAG_W-1:0] IMPACT_BIT =
    mec_pkg::FLAG_W'(1 << mec_pkg::FLAG_IMPACT);
  localparam logic [mec_pkg::FLAG_W-1:0] MOTION_BIT =
    mec_pkg::FLAG_W'(1 << mec_pkg::FLAG_MOTION);
  localparam logic [mec_pkg::FLAG_W-1:0] WAKE_BIT   =
    mec_pkg::FLAG_W'(1 << mec_pkg::FLAG_WAKE);
  localparam int PHASE_ITEMS = 220;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we;
  logic [mec_pkg::LEVEL_W-1:0] cfg_wdata;
  int                          send_idle_pct;
  int                          recv_stall_pct;
  motion_tally                 tally = new();

  mec_in_if  in_if ();
  mec_out_if out_if ();

  motion_event_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic signed [mec_pkg::AXIS_W-1:0] jitter(int span);
    int v;
    v = int'($urandom_range(2 * span)) - span;
    return mec_pkg::AXIS_W'(v);
  endfunction

  function automatic sample_t build(int ax, int ay, int az, int gx, int gy, int gz,
                                    logic [mec_pkg::FLAG_W-1:0] flags, logic armed,
                                    logic active, logic [mec_pkg::TIME_W-1:0] now,
                                    logic clr);
    sample_t s;
    s.acc[0] = mec_pkg::AXIS_W'(ax);
    s.acc[1] = mec_pkg::AXIS_W'(ay);
    s.acc[2] = mec_pkg::AXIS_W'(az);
    s.gyr[0] = mec_pkg::AXIS_W'(gx);
    s.gyr[1] = mec_pkg::AXIS_W'(gy);
    s.gyr[2] = mec_pkg::AXIS_W'(gz);
    s.flags  = flags;
    s.armed  = armed;
    s.active = active;
    s.now    = now;
    s.clr    = clr;
    return s;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int kind;
    int spread;
    int axis;
    int v;
    kind = $urandom_range(9);
    if (kind < 2) begin
      for (int i = 0; i < 3; i++) s.acc[i] = mec_pkg::AXIS_W'($urandom);
    end else if (kind < 7) begin
      // mostly near one g along one axis, deviation spread over every threshold row
      case ($urandom_range(2))
        0:       spread = 60;
        1:       spread = 400;
        default: spread = 3000;
      endcase
      axis = $urandom_range(2);
      for (int i = 0; i < 3; i++) s.acc[i] = jitter(spread / 4);
      v = int'(ONE_G_COUNTS) + int'(jitter(spread));
      s.acc[axis] = mec_pkg::AXIS_W'($urandom_range(1) ? v : -v);
    end else begin
      for (int i = 0; i < 3; i++) s.acc[i] = jitter(6000);
    end
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      if (kind < 2)      s.gyr[i] = mec_pkg::AXIS_W'($urandom);
      else if (kind < 6) s.gyr[i] = jitter(20);
      else               s.gyr[i] = jitter(1200);
    end
    s.flags  = ($urandom_range(9) < 7) ? '0 : mec_pkg::FLAG_W'($urandom_range(7));
    s.armed  = 1'($urandom_range(1));
    s.active = 1'($urandom_range(1));
    s.now    = mec_pkg::TIME_W'({$urandom, $urandom});
    s.clr    = ($urandom_range(19) == 0);
    return s;
  endfunction

  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.accel_x       <= s.acc[0];
    in_if.accel_y       <= s.acc[1];
    in_if.accel_z       <= s.acc[2];
    in_if.gyro_x        <= s.gyr[0];
    in_if.gyro_y        <= s.gyr[1];
    in_if.gyro_z        <= s.gyr[2];
    in_if.sensor_flags  <= s.flags;
    in_if.armed         <= s.armed;
    in_if.active_state  <= s.active;
    in_if.now_us        <= s.now;
    in_if.clear_metrics <= s.clr;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    tally.note_sample(s);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (tally.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_level(logic [mec_pkg::LEVEL_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    tally.write_level(v);
  endtask

  // result side: check each transfer, then pick the next ready
  initial begin : result_sink
    report_t got;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.cls       = mec_pkg::class_e'(out_if.event_class);
        got.fwd       = out_if.forward_event;
        got.peak_dev  = out_if.peak_accel_dev;
        got.peak_gyro = out_if.peak_gyro_mag;
        got.hard_cnt  = out_if.hard_count;
        got.soft_cnt  = out_if.soft_count;
        got.move_time = out_if.last_move_time;
        got.hard_time = out_if.last_hard_time;
        tally.check_report(got);
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_levels [8];
    int unsigned g;
    int unsigned a_soft;
    int unsigned a_hard;
    phase_levels = '{0, 4, 7, 1, 5, 3, 6, 2};
    g      = ONE_G_COUNTS;
    // level 2 limits, the row in force after reset
    a_soft = ACC_SOFT_MG[2] * ONE_G_COUNTS / 1000;
    a_hard = ACC_HARD_MG[2] * ONE_G_COUNTS / 1000;

    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    in_if.valid         = 1'b0;
    in_if.accel_x       = '0;
    in_if.accel_y       = '0;
    in_if.accel_z       = '0;
    in_if.gyro_x        = '0;
    in_if.gyro_y        = '0;
    in_if.gyro_z        = '0;
    in_if.sensor_flags  = '0;
    in_if.armed         = 1'b0;
    in_if.active_state  = 1'b0;
    in_if.now_us        = '0;
    in_if.clear_metrics = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero vector is a full g off rest, so hard
    send_sample(build(0, 0, 0, 0, 0, 0, '0, 1'b1, 1'b0, 48'h1, 1'b0));
    // at rest with clear: peaks and counters drop, timestamps stay
    send_sample(build(g, 0, 0, 0, 0, 0, '0, 1'b0, 1'b0, 48'h2, 1'b1));
    send_sample(build(-g, 0, 0, 0, 0, 0, '0, 1'b1, 1'b1, 48'h3, 1'b0));
    // accel deviation on and just past each limit
    send_sample(build(g + a_soft, 0, 0, 0, 0, 0, '0, 1'b1, 1'b0, 48'h4, 1'b0));
    send_sample(build(g + a_soft + 1, 0, 0, 0, 0, 0, '0, 1'b0, 1'b1, 48'h5, 1'b0));
    send_sample(build(g + a_hard, 0, 0, 0, 0, 0, '0, 1'b0, 1'b0, 48'h6, 1'b0));
    send_sample(build(0, -(g + a_hard + 1), 0, 0, 0, 0, '0, 1'b1, 1'b1, 48'h7, 1'b0));
    // gyro magnitude on and just past each limit
    send_sample(build(0, 0, g, GYRO_SOFT_CT[2], 0, 0, '0, 1'b1, 1'b0, 48'h8, 1'b0));
    send_sample(build(0, 0, g, 0, GYRO_SOFT_CT[2] + 1, 0, '0, 1'b1, 1'b0, 48'h9, 1'b0));
    send_sample(build(0, 0, g, 0, 0, GYRO_HARD_CT[2], '0, 1'b1, 1'b0, 48'hA, 1'b0));
    send_sample(build(0, 0, g, -(GYRO_HARD_CT[2] + 1), 0, 0, '0, 1'b0, 1'b1, 48'hB, 1'b0));
    // flag-driven classes with the sample at rest
    send_sample(build(g, 0, 0, 0, 0, 0, IMPACT_BIT, 1'b0, 1'b0, 48'hC, 1'b0));
    send_sample(build(g, 0, 0, 0, 0, 0, MOTION_BIT, 1'b1, 1'b0, 48'hD, 1'b0));
    send_sample(build(g, 0, 0, 0, 0, 0, WAKE_BIT, 1'b0, 1'b1, 48'hE, 1'b0));
    send_sample(build(g, 0, 0, 0, 0, 0, '1, 1'b1, 1'b1, 48'hF, 1'b0));
    // full-scale vectors and extreme timestamps
    send_sample(build(-32768, -32768, -32768, -32768, -32768, -32768, '0, 1'b1, 1'b0,
                      48'hFFFF_FFFF_FFFF, 1'b0));
    send_sample(build(32767, 32767, 32767, 32767, 32767, 32767, '0, 1'b0, 1'b1,
                      48'hAAAA_AAAA_AAAA, 1'b0));
    send_sample(build(32767, -32768, 0, -32768, 32767, 0, '0, 1'b1, 1'b1,
                      48'h5555_5555_5555, 1'b1));
    send_sample(build(g, 0, 0, 0, 0, 0, MOTION_BIT, 1'b0, 1'b0, 48'h0, 1'b1));

    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      write_level(mec_pkg::LEVEL_W'(phase_levels[phase]));
      case (phase % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      repeat (PHASE_ITEMS) send_sample(random_sample());
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (tally.errors == 0 && tally.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/mec_pkg.sv
rtl/mec_if.sv
rtl/mec_front.sv
rtl/mec_queue.sv
rtl/mec_back.sv
rtl/motion_event_classifier.sv
dv/motion_event_classifier_test.sv
